### hw/rtl/mrsg_pkg.sv
// Package for the move/rotate step generator.
// Holds field widths, command and register codes, speed caps and the
// saturation and per-tick bite functions. No dependencies.
package mrsg_pkg;

   // Field widths
   localparam int CmdW    = 3;
   localparam int AmtW    = 32;
   localparam int StepW   = 22;
   localparam int OdoW    = 48;
   localparam int CsrIdxW = 1;

   // Command codes
   localparam logic [CmdW-1:0] CMD_TICK       = 3'd0;
   localparam logic [CmdW-1:0] CMD_MOVE_BY    = 3'd1;
   localparam logic [CmdW-1:0] CMD_ROTATE_BY  = 3'd2;
   localparam logic [CmdW-1:0] CMD_CONTINUOUS = 3'd3;
   localparam logic [CmdW-1:0] CMD_CANCEL     = 3'd4;

   // Register indexes
   localparam logic [CsrIdxW-1:0] CSR_MOVE_SPEED = 1'd0;
   localparam logic [CsrIdxW-1:0] CSR_TURN_SPEED = 1'd1;

   // Speed limits: the per-axis maximum, never above 16.0 in Q16.16
   localparam int MAX_MOVE_SPEED = 1048576;
   localparam int MAX_TURN_SPEED = 1048576;
   localparam int SpeedCeil      = 1048576;
   localparam int MoveCap        = (MAX_MOVE_SPEED < SpeedCeil) ? MAX_MOVE_SPEED : SpeedCeil;
   localparam int TurnCap        = (MAX_TURN_SPEED < SpeedCeil) ? MAX_TURN_SPEED : SpeedCeil;

   // Ready threshold: magnitude below 0.1 in Q16.16
   localparam int ReadyLimit = 6554;

   typedef logic signed [StepW-1:0] step_type;
   typedef logic signed [AmtW-1:0]  amt_type;
   typedef logic signed [OdoW-1:0]  odo_type;

   // Clamp a signed speed to +/- cap
   function automatic step_type sat_speed(input step_type v, input step_type cap);
      step_type r;
      r = v;
      if (v > cap) begin
         r = cap;
      end else if (v < -cap) begin
         r = -cap;
      end
      return r;
   endfunction

   // Magnitude of a remainder, one bit wider so the most negative value fits
   function automatic logic [AmtW:0] rem_mag(input amt_type rem);
      logic [AmtW:0] x;
      x = {rem[AmtW-1], rem};
      return rem[AmtW-1] ? (~x + 1'b1) : x;
   endfunction

   // Bite of the remainder: the remainder itself, or |speed| with the remainder's sign
   function automatic step_type bite(input amt_type rem, input step_type spd);
      step_type a;
      step_type r;
      a = spd[StepW-1] ? -spd : spd;
      r = rem[StepW-1:0];
      if (rem_mag(rem) > {{(AmtW+1-StepW){1'b0}}, a}) begin
         r = rem[AmtW-1] ? -a : a;
      end
      return r;
   endfunction

endpackage

### hw/rtl/mrsg_req_if.sv
// Command channel of the move/rotate step generator.
// Depends on mrsg_pkg.
interface mrsg_req_if;
   import mrsg_pkg::*;

   logic            valid;
   logic            ready;
   logic [CmdW-1:0] command;
   amt_type         amount;

   modport source (output valid, output command, output amount, input ready);
   modport sink   (input valid, input command, input amount, output ready);
endinterface

### hw/rtl/mrsg_rsp_if.sv
// Result channel of the move/rotate step generator.
// Depends on mrsg_pkg.
interface mrsg_rsp_if;
   import mrsg_pkg::*;

   logic     valid;
   logic     ready;
   step_type step_move;
   step_type step_turn;
   logic     ready_res;
   odo_type  travelled;
   odo_type  turned;

   modport source (output valid, output step_move, output step_turn, output ready_res,
                   output travelled, output turned, input ready);
   modport sink   (input valid, input step_move, input step_turn, input ready_res,
                   input travelled, input turned, output ready);
endinterface

### hw/rtl/mrsg_csr_if.sv
// Register write channel of the move/rotate step generator.
// Depends on mrsg_pkg.
interface mrsg_csr_if;
   import mrsg_pkg::*;

   logic               valid;
   logic               ready;
   logic [CsrIdxW-1:0] index;
   step_type           data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/move_rotate_step_generator.sv
// Top level of the move/rotate step generator.
// Depends on mrsg_pkg and the mrsg_req_if, mrsg_rsp_if and mrsg_csr_if interfaces.
//
// One command beat in, one result beat out, at a sustained rate of one beat per
// clock while the output is not stalled. A command is captured in an input
// register and resolved into the result register when the result slot is free.
// Remainders, mode flag and odometers change only when a result is loaded, so
// travelled, turned and ready_res are read straight from that state. The speed
// registers are saturated to their limits as they are written; write them only
// while no command is in flight. Register writes are always accepted.
module move_rotate_step_generator (
   input  logic           clock,
   input  logic           reset,
   mrsg_req_if.sink       req_bus,
   mrsg_rsp_if.source     rsp_bus,
   mrsg_csr_if.sink       csr_bus
);
   import mrsg_pkg::*;

   // Speed registers, stored already saturated
   step_type move_spd_ff, move_spd_in;
   step_type turn_spd_ff, turn_spd_in;

   // Input register
   logic            stg_vld_ff, stg_vld_in;
   logic [CmdW-1:0] stg_cmd_ff, stg_cmd_in;
   amt_type         stg_amt_ff, stg_amt_in;

   // Motion state
   logic    cont_ff, cont_in;
   amt_type rem_dist_ff, rem_dist_in;
   amt_type rem_ang_ff, rem_ang_in;
   odo_type odo_lin_ff, odo_lin_in;
   odo_type odo_ang_ff, odo_ang_in;

   // Result register
   logic     rsp_vld_ff, rsp_vld_in;
   step_type step_move_ff, step_move_in;
   step_type step_turn_ff, step_turn_in;

   logic     advance;
   logic     req_take;
   step_type sm;
   step_type st;

   // Handshake: input register moves on when the result slot is free
   assign advance  = stg_vld_ff && (!rsp_vld_ff || rsp_bus.ready);
   assign req_take = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !stg_vld_ff || advance;
   assign csr_bus.ready = 1'b1;

   // Register writes
   always_comb begin
      move_spd_in = move_spd_ff;
      turn_spd_in = turn_spd_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_MOVE_SPEED: move_spd_in = sat_speed(csr_bus.data, StepW'(MoveCap));
            CSR_TURN_SPEED: turn_spd_in = sat_speed(csr_bus.data, StepW'(TurnCap));
         endcase
      end
   end

   // Input register next values
   always_comb begin
      stg_vld_in = stg_vld_ff;
      stg_cmd_in = stg_cmd_ff;
      stg_amt_in = stg_amt_ff;
      if (req_take) begin
         stg_vld_in = 1'b1;
         stg_cmd_in = req_bus.command;
         stg_amt_in = req_bus.amount;
      end else if (advance) begin
         stg_vld_in = 1'b0;
      end
   end

   // Command execution
   always_comb begin
      sm          = '0;
      st          = '0;
      cont_in     = cont_ff;
      rem_dist_in = rem_dist_ff;
      rem_ang_in  = rem_ang_ff;
      case (stg_cmd_ff)
         CMD_TICK: begin
            if (cont_ff) begin
               sm = move_spd_ff;
               st = turn_spd_ff;
            end else begin
               sm          = bite(rem_dist_ff, move_spd_ff);
               st          = bite(rem_ang_ff, turn_spd_ff);
               rem_dist_in = rem_dist_ff - AmtW'(sm);
               rem_ang_in  = rem_ang_ff - AmtW'(st);
            end
         end
         CMD_MOVE_BY: begin
            cont_in     = 1'b0;
            rem_dist_in = stg_amt_ff;
         end
         CMD_ROTATE_BY: begin
            cont_in    = 1'b0;
            rem_ang_in = stg_amt_ff;
         end
         CMD_CONTINUOUS: begin
            cont_in     = 1'b1;
            rem_dist_in = '0;
            rem_ang_in  = '0;
         end
         CMD_CANCEL: begin
            cont_in     = 1'b0;
            rem_dist_in = '0;
            rem_ang_in  = '0;
         end
         default: begin
         end
      endcase
      odo_lin_in   = odo_lin_ff + OdoW'(sm);
      odo_ang_in   = odo_ang_ff + OdoW'(st);
      step_move_in = sm;
      step_turn_in = st;
   end

   // Result valid
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (advance) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         move_spd_ff <= '0;
         turn_spd_ff <= '0;
         stg_vld_ff  <= 1'b0;
         cont_ff     <= 1'b0;
         rem_dist_ff <= '0;
         rem_ang_ff  <= '0;
         odo_lin_ff  <= '0;
         odo_ang_ff  <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         move_spd_ff <= move_spd_in;
         turn_spd_ff <= turn_spd_in;
         stg_vld_ff  <= stg_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         if (advance) begin
            cont_ff     <= cont_in;
            rem_dist_ff <= rem_dist_in;
            rem_ang_ff  <= rem_ang_in;
            odo_lin_ff  <= odo_lin_in;
            odo_ang_ff  <= odo_ang_in;
         end
      end
      stg_cmd_ff <= stg_cmd_in;
      stg_amt_ff <= stg_amt_in;
      if (advance) begin
         step_move_ff <= step_move_in;
         step_turn_ff <= step_turn_in;
      end
   end

   // Outputs
   assign rsp_bus.valid     = rsp_vld_ff;
   assign rsp_bus.step_move = step_move_ff;
   assign rsp_bus.step_turn = step_turn_ff;
   assign rsp_bus.travelled = odo_lin_ff;
   assign rsp_bus.turned    = odo_ang_ff;
   assign rsp_bus.ready_res = (rem_mag(rem_dist_ff) < (AmtW+1)'(ReadyLimit)) &&
                              (rem_mag(rem_ang_ff) < (AmtW+1)'(ReadyLimit));

   // Checks
   a_advance_loads: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_vld_ff)
      else $error("result not offered after advance");

   a_non_tick_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && stg_cmd_ff != CMD_TICK) |=> (step_move_ff == '0 && step_turn_ff == '0))
      else $error("non-tick command produced a step");

   a_cont_no_rem: assert property (@(posedge clock) disable iff (reset)
      cont_ff |-> (rem_dist_ff == '0 && rem_ang_ff == '0))
      else $error("remainder pending in continuous mode");

endmodule
